// ===== src/pbte_pkg.sv =====
package pbte_pkg;

    localparam int COLOR_W         = 32;
    localparam int TILE_W          = 8;
    localparam int PIXELS_PER_TILE = 8;
    localparam int POS_W           = 3;
    localparam int STORED_W        = 5;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 3;

    // Register word index taken from paddr[2].
    localparam logic REG_LEARN_COLORS = 1'b0;

    // Per-pixel outcome of the palette lookup.
    typedef struct packed {
        logic                palette_overflow;
        logic [STORED_W-1:0] colors_stored;
        logic                high_bit;
        logic                low_bit;
    } pal_status_t;

    // One result word, first field in the highest bits.
    typedef struct packed {
        logic                palette_overflow;
        logic [STORED_W-1:0] colors_stored;
        logic [TILE_W-1:0]   plane_high;
        logic [TILE_W-1:0]   plane_low;
    } tile_t;

    localparam int TILE_BITS = $bits(tile_t);
    localparam int TDATA_W   = ((TILE_BITS + 7) / 8) * 8;

endpackage

// ===== src/pbte_palette.sv =====
module pbte_palette #(
    parameter int PALETTE_DEPTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic                         learn,
    input  logic [pbte_pkg::COLOR_W-1:0] color,
    input  logic                         clear,
    output pbte_pkg::pal_status_t        status
);

    localparam int IDX_W = $clog2(PALETTE_DEPTH);
    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

    logic [pbte_pkg::COLOR_W-1:0] palette_reg [PALETTE_DEPTH];
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         overflow_reg;
    logic                         overflow_next;

    logic [CNT_W-1:0]                      count_eff;
    logic                                  ovf_eff;
    logic                                  hit;
    logic [IDX_W-1:0]                      idx;
    logic                                  full;
    logic                                  store;
    logic                                  coded;
    logic [IDX_W-1:0]                      code;
    logic [CNT_W+pbte_pkg::STORED_W-1:0]   cnt_ext;

    always_comb begin
        count_eff = clear ? '0 : count_reg;
        ovf_eff   = clear ? 1'b0 : overflow_reg;

        // Every held entry is compared at once; the lowest matching index wins.
        hit = 1'b0;
        idx = '0;
        for (int i = PALETTE_DEPTH - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < count_eff) && (palette_reg[i] == color)) begin
                hit = 1'b1;
                idx = IDX_W'(i);
            end
        end

        full          = (count_eff >= CNT_W'(PALETTE_DEPTH));
        store         = !hit && learn && !full;
        count_next    = store ? count_eff + CNT_W'(1) : count_eff;
        overflow_next = ovf_eff | (!hit && learn && full);

        code  = store ? count_eff[IDX_W-1:0] : idx;
        coded = hit || store;

        cnt_ext = {{pbte_pkg::STORED_W{1'b0}}, count_next};

        status.low_bit          = coded && ((code == IDX_W'(1)) || (code == IDX_W'(3)));
        status.high_bit         = coded && ((code == IDX_W'(2)) || (code == IDX_W'(3)));
        status.colors_stored    = cnt_ext[pbte_pkg::STORED_W-1:0];
        status.palette_overflow = overflow_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end else if (step) begin
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && store) begin
            palette_reg[count_eff[IDX_W-1:0]] <= color;
        end
    end

endmodule

// ===== src/pbte_planes.sv =====
module pbte_planes (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic                        clear,
    input  pbte_pkg::pal_status_t       status,
    output logic                        emit,
    output logic [pbte_pkg::TILE_W-1:0] plane_low,
    output logic [pbte_pkg::TILE_W-1:0] plane_high
);

    logic [pbte_pkg::POS_W-1:0]  bit_pos_reg;
    logic [pbte_pkg::POS_W-1:0]  bit_pos_next;
    logic [pbte_pkg::TILE_W-1:0] low_reg;
    logic [pbte_pkg::TILE_W-1:0] low_next;
    logic [pbte_pkg::TILE_W-1:0] high_reg;
    logic [pbte_pkg::TILE_W-1:0] high_next;

    logic [pbte_pkg::POS_W-1:0]  pos_eff;
    logic [pbte_pkg::TILE_W-1:0] low_eff;
    logic [pbte_pkg::TILE_W-1:0] high_eff;

    always_comb begin
        pos_eff  = clear ? '0 : bit_pos_reg;
        low_eff  = clear ? '0 : low_reg;
        high_eff = clear ? '0 : high_reg;

        plane_low  = {low_eff[pbte_pkg::TILE_W-2:0], status.low_bit};
        plane_high = {high_eff[pbte_pkg::TILE_W-2:0], status.high_bit};
        emit       = (pos_eff == pbte_pkg::POS_W'(pbte_pkg::PIXELS_PER_TILE - 1));

        // The shifters start over once a full tile row has gone out.
        if (emit) begin
            bit_pos_next = '0;
            low_next     = '0;
            high_next    = '0;
        end else begin
            bit_pos_next = pos_eff + pbte_pkg::POS_W'(1);
            low_next     = plane_low;
            high_next    = plane_high;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_pos_reg <= '0;
            low_reg     <= '0;
            high_reg    <= '0;
        end else if (step) begin
            bit_pos_reg <= bit_pos_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
        end
    end

endmodule

// ===== src/palette_bitplane_tile_encoder.sv =====
// Palette-indexed 2-bit planar tile encoder.
// Pixels enter on the s_ stream, one RGBA word per transfer, with s_tuser
// asking for the palette to be emptied before that pixel is handled. Each
// pixel is looked up in a palette of PALETTE_DEPTH colors held in flip-flops
// and compared in parallel; with learning on, unseen colors are appended.
// After every eighth pixel one word leaves on the m_ stream carrying both
// plane bytes, the palette fill count and the overflow flag.
// A pixel is registered at acceptance and processed from that register, and
// the result word that its eighth pixel finishes is registered in the output
// register and presented from there until it is taken.
// One pixel is taken per cycle, limited by the palette compare and update,
// unless a finished word stalls; a result word goes out every eight pixels.
// The output word is held in a register, so pixels keep flowing while a word
// waits; only a second finished word stalls the input, through s_tready.
// Synchronous active-low reset empties the palette, clears the shifters and the
// bit position, and sets learn_colors to 1. Register learn_colors is at APB byte
// address 0; the user must write it only while the stream is idle (unchecked).
module palette_bitplane_tile_encoder #(
    parameter int PALETTE_DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pbte_pkg::COLOR_W-1:0]    s_tdata,  // red, green, blue, alpha
    input  logic                            s_tuser,  // clear_palette

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // plane_low, plane_high, colors_stored, palette_overflow, zero pad
    output logic [pbte_pkg::TDATA_W-1:0]    m_tdata,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pbte_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pbte_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pbte_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    logic                         learn_reg;
    logic                         in_valid_reg;
    logic                         in_valid_next;
    logic [pbte_pkg::COLOR_W-1:0] pix_reg;
    logic                         clr_reg;
    logic                         m_valid_reg;
    logic                         m_valid_next;
    pbte_pkg::tile_t              m_data_reg;

    pbte_pkg::pal_status_t        status;
    logic                         emit;
    logic [pbte_pkg::TILE_W-1:0]  plane_low;
    logic [pbte_pkg::TILE_W-1:0]  plane_high;
    logic                         fire;
    logic                         s_accept;
    logic                         out_load;

    // APB register access.
    assign pready = 1'b1;

    always_comb begin
        prdata = '0;
        if (paddr[2] == pbte_pkg::REG_LEARN_COLORS) begin
            prdata[0] = learn_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            learn_reg <= 1'b1;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == pbte_pkg::REG_LEARN_COLORS)) begin
            learn_reg <= pwdata[0];
        end
    end

    // A pixel that finishes a tile needs room in the output register.
    assign fire     = in_valid_reg && (!emit || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;
    assign out_load = fire && emit;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pix_reg <= s_tdata;
            clr_reg <= s_tuser;
        end
        if (out_load) begin
            m_data_reg.plane_low        <= plane_low;
            m_data_reg.plane_high       <= plane_high;
            m_data_reg.colors_stored    <= status.colors_stored;
            m_data_reg.palette_overflow <= status.palette_overflow;
        end
    end

    pbte_palette #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (fire),
        .learn   (learn_reg),
        .color   (pix_reg),
        .clear   (clr_reg),
        .status  (status)
    );

    pbte_planes u_planes (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (fire),
        .clear      (clr_reg),
        .status     (status),
        .emit       (emit),
        .plane_low  (plane_low),
        .plane_high (plane_high)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(pbte_pkg::TDATA_W - pbte_pkg::TILE_BITS){1'b0}}, m_data_reg};

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int PAL_DEPTH    = 16;
    localparam int DRAIN_CYCLES = 8;
    localparam int TIMEOUT_NS   = 5_000_000;

    localparam logic [pbte_pkg::APB_ADDR_W-1:0] ADDR_LEARN  =
        {pbte_pkg::REG_LEARN_COLORS, 2'b00};
    localparam logic [pbte_pkg::APB_ADDR_W-1:0] ADDR_UNUSED =
        {~pbte_pkg::REG_LEARN_COLORS, 2'b00};

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [pbte_pkg::COLOR_W-1:0]    s_tdata;   // red, green, blue, alpha
    logic                            s_tuser;   // clear_palette
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // plane_low, plane_high, colors_stored, palette_overflow, zero pad
    logic [pbte_pkg::TDATA_W-1:0]    m_tdata;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [pbte_pkg::APB_ADDR_W-1:0] paddr;
    logic [pbte_pkg::APB_DATA_W-1:0] pwdata;
    logic [pbte_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    // Palette encoder state as the block should hold it.
    logic [pbte_pkg::COLOR_W-1:0] pal_colors [PAL_DEPTH];
    int                           pal_count = 0;
    logic [pbte_pkg::POS_W-1:0]   tile_pos  = '0;
    logic [pbte_pkg::TILE_W-1:0]  low_sr    = '0;
    logic [pbte_pkg::TILE_W-1:0]  high_sr   = '0;
    logic                         ovf_seen  = 1'b0;
    logic                         learn_on  = 1'b1;

    pbte_pkg::tile_t tiles_expected[$];
    pbte_pkg::tile_t tile_got;
    pbte_pkg::tile_t tile_want;

    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    int error_count    = 0;
    int pixels_sent    = 0;
    int clears_sent    = 0;
    int words_checked  = 0;
    int overflow_words = 0;

    palette_bitplane_tile_encoder #(
        .PALETTE_DEPTH(PAL_DEPTH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        #(TIMEOUT_NS);
        $display("** palette_bitplane_tile_encoder: FAILED **");
        $finish;
    end

    // Updates the palette state for one accepted pixel and queues the tile
    // word when this pixel completes a group of eight.
    function automatic void encode_pixel(input logic [pbte_pkg::COLOR_W-1:0] color,
                                         input logic clr);
        int              idx    = 0;
        bit              hit    = 1'b0;
        bit              low_b  = 1'b0;
        bit              high_b = 1'b0;
        pbte_pkg::tile_t word;
        if (clr) begin
            pal_count = 0;
            tile_pos  = '0;
            low_sr    = '0;
            high_sr   = '0;
            ovf_seen  = 1'b0;
        end
        for (int i = 0; i < pal_count; i++) begin
            if (!hit && pal_colors[i] == color) begin
                hit = 1'b1;
                idx = i;
            end
        end
        if (!hit && learn_on) begin
            if (pal_count < PAL_DEPTH) begin
                pal_colors[pal_count] = color;
                idx = pal_count;
                pal_count++;
                hit = 1'b1;
            end else begin
                ovf_seen = 1'b1;
            end
        end
        if (hit) begin
            low_b  = (idx == 1 || idx == 3);
            high_b = (idx == 2 || idx == 3);
        end
        low_sr  = {low_sr[pbte_pkg::TILE_W-2:0], low_b};
        high_sr = {high_sr[pbte_pkg::TILE_W-2:0], high_b};
        if (tile_pos == pbte_pkg::PIXELS_PER_TILE - 1) begin
            word.plane_low        = low_sr;
            word.plane_high       = high_sr;
            word.colors_stored    = pbte_pkg::STORED_W'(pal_count);
            word.palette_overflow = ovf_seen;
            tiles_expected = {tiles_expected, word};
            low_sr   = '0;
            high_sr  = '0;
            tile_pos = '0;
        end else begin
            tile_pos = tile_pos + 1'b1;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tile_got = m_tdata[pbte_pkg::TILE_BITS-1:0];
            if (tiles_expected.size() == 0) begin
                $display("%0t: unexpected tile word, expected none, actual %h", $time, m_tdata);
                error_count++;
            end else begin
                tile_want = tiles_expected.pop_front();
                words_checked++;
                if (tile_want.palette_overflow) overflow_words++;
                if (tile_got.plane_low !== tile_want.plane_low) begin
                    $display("%0t: plane_low expected %h actual %h",
                             $time, tile_want.plane_low, tile_got.plane_low);
                    error_count++;
                end
                if (tile_got.plane_high !== tile_want.plane_high) begin
                    $display("%0t: plane_high expected %h actual %h",
                             $time, tile_want.plane_high, tile_got.plane_high);
                    error_count++;
                end
                if (tile_got.colors_stored !== tile_want.colors_stored) begin
                    $display("%0t: colors_stored expected %0d actual %0d",
                             $time, tile_want.colors_stored, tile_got.colors_stored);
                    error_count++;
                end
                if (tile_got.palette_overflow !== tile_want.palette_overflow) begin
                    $display("%0t: palette_overflow expected %b actual %b",
                             $time, tile_want.palette_overflow, tile_got.palette_overflow);
                    error_count++;
                end
            end
        end
    end

    task automatic send_pixel(input logic [pbte_pkg::COLOR_W-1:0] color, input logic clr);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= color;
        s_tuser  <= clr;
        do @(posedge aclk); while (!s_tready);
        encode_pixel(color, clr);
        pixels_sent++;
        if (clr) clears_sent++;
    endtask

    // A pixel that does not finish a tile leaves no word behind, so the task keeps
    // waiting after the queue empties to let the last one settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (tiles_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [pbte_pkg::APB_ADDR_W-1:0] addr,
                            input logic [pbte_pkg::APB_DATA_W-1:0] wdata,
                            output logic [pbte_pkg::APB_DATA_W-1:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Only bit 0 of the value counts; the write to the unused word must not
    // disturb the register.
    task automatic set_learning(input logic [pbte_pkg::APB_DATA_W-1:0] value);
        logic [pbte_pkg::APB_DATA_W-1:0] rd;
        drain_results();
        apb_xfer(1'b1, ADDR_LEARN, value, rd);
        learn_on = value[0];
        apb_xfer(1'b1, ADDR_UNUSED, ~value, rd);
        apb_xfer(1'b0, ADDR_LEARN, '0, rd);
        if (rd !== {{(pbte_pkg::APB_DATA_W-1){1'b0}}, learn_on}) begin
            $display("%0t: learn_colors readback expected %h actual %h",
                     $time, {{(pbte_pkg::APB_DATA_W-1){1'b0}}, learn_on}, rd);
            error_count++;
        end
    endtask

    function automatic logic [pbte_pkg::COLOR_W-1:0] directed_color(input int k);
        case (k)
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h00FF_00FF;
            3:       return 32'hFF00_FF00;
            4:       return 32'h8040_2010;
            5:       return 32'h0102_0408;
            6:       return 32'h7F7F_7F7F;
            7:       return 32'h8080_8080;
            8:       return 32'h1122_3344;
            9:       return 32'h5566_7788;
            10:      return 32'h99AA_BBCC;
            11:      return 32'hDDEE_FF00;
            12:      return 32'h0F0F_0F0F;
            13:      return 32'hF0F0_F0F0;
            14:      return 32'h0000_00FF;
            15:      return 32'hFF00_0000;
            default: return 32'h3C3C_A5A5;
        endcase
    endfunction

    // Sixteen distinct colors fill the palette exactly; the first two tiles
    // cover every index class.
    task automatic test_palette_fill();
        for (int k = 0; k < PAL_DEPTH; k++) begin
            send_pixel(directed_color(k), k == 0);
        end
    endtask

    task automatic test_full_palette();
        send_pixel(directed_color(PAL_DEPTH), 1'b0);
        send_pixel(directed_color(1), 1'b0);
        send_pixel(directed_color(2), 1'b0);
    endtask

    task automatic test_learning_off();
        set_learning(32'hFFFF_FFFE);
        send_pixel(32'h0BAD_F00D, 1'b0);
        send_pixel(directed_color(3), 1'b0);
    endtask

    // The clear drops the five pixels already in the tile.
    task automatic test_clear_request();
        send_pixel(directed_color(3), 1'b1);
    endtask

    task automatic test_random_traffic(input int n_items, input logic learn);
        logic [pbte_pkg::COLOR_W-1:0] pool [20];
        int                           pool_size;
        logic [pbte_pkg::COLOR_W-1:0] color;
        set_learning(({$urandom} & ~32'h1) | {{(pbte_pkg::APB_DATA_W-1){1'b0}}, learn});
        pool_size = $urandom_range(3, 20);
        foreach (pool[k]) pool[k] = $urandom;
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(99) < 10) begin
                color = $urandom;
            end else begin
                color = pool[$urandom_range(pool_size - 1)];
            end
            send_pixel(color, $urandom_range(99) < 2);
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        tx_idle_pct = 33;
        rx_idle_pct = 68;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_palette_fill();
        test_full_palette();
        test_learning_off();
        test_clear_request();

        for (int b = 0; b < 12; b++) begin
            if (b == 4) begin
                tx_idle_pct = 68;
                rx_idle_pct = 33;
            end
            if (b == 8) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            test_random_traffic(120, (b % 3) != 2);
        end
        drain_results();

        $display("Encoded %0d pixels (%0d with a palette clear) with learning on and off.",
                 pixels_sent, clears_sent);
        $display("Checked %0d tile words, %0d of them with the overflow flag set.",
                 words_checked, overflow_words);
        if (error_count == 0) begin
            $display("** palette_bitplane_tile_encoder: PASSED **");
        end else begin
            $display("** palette_bitplane_tile_encoder: FAILED **");
        end
        $finish;
    end

endmodule
